// ===== rtl/psbd_pkg.sv =====
// Package with shared constants and types for the point-set bounds block.
package psbd_pkg;

    localparam int MaxVertices = 4096;
    localparam int CoordBits   = 24;
    localparam int DiamBits    = 25;
    localparam int CountBits   = $clog2(MaxVertices) + 1;
    localparam int AddrBits    = $clog2(MaxVertices);
    localparam int SqBits      = 2 * DiamBits + 1;
    localparam int VecBits     = 3 * CoordBits;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RD,
        ST_WAIT,
        ST_DX,
        ST_DY,
        ST_DZ,
        ST_SUM,
        ST_SQRT,
        ST_OUT
    } t_state;

    // Squared-distance unit control.
    typedef struct packed {
        logic       start;
        logic [1:0] axis;
    } t_sq_ctl;

endpackage

// ===== rtl/psbd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module psbd_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/psbd_sq_unit.sv =====
// Shared squaring unit: one axis difference squared and accumulated per cycle while i_en is high.
module psbd_sq_unit (
    input  logic                                 i_clk,
    input  psbd_pkg::t_sq_ctl                    i_ctl,
    input  logic                                 i_en,
    input  logic signed [psbd_pkg::CoordBits-1:0] i_a,
    input  logic signed [psbd_pkg::CoordBits-1:0] i_b,
    output logic [psbd_pkg::SqBits-1:0]          o_sum
);

    logic signed [psbd_pkg::CoordBits:0] w_diff;
    logic [psbd_pkg::CoordBits:0]        w_abs;
    logic [psbd_pkg::SqBits-1:0]         w_prod;
    logic [psbd_pkg::SqBits:0]           w_add;
    logic [psbd_pkg::SqBits-1:0]         r_sum;

    // Absolute difference and its square (at most 25 by 25 bits).
    always_comb begin
        w_diff = {i_a[psbd_pkg::CoordBits-1], i_a} - {i_b[psbd_pkg::CoordBits-1], i_b};
        w_abs  = w_diff[psbd_pkg::CoordBits] ?
                 (psbd_pkg::CoordBits+1)'(0) - w_diff : w_diff;
        w_prod = psbd_pkg::SqBits'(w_abs) * psbd_pkg::SqBits'(w_abs);
        w_add  = {1'b0, (i_ctl.start ? psbd_pkg::SqBits'(0) : r_sum)} + {1'b0, w_prod};
    end

    // Accumulate across three axes; the sum stays below 2^51.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= w_add[psbd_pkg::SqBits-1:0];
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== rtl/psbd_sqrt.sv =====
// Bit-serial floor square root, one result bit per cycle.
module psbd_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [psbd_pkg::SqBits-1:0]   i_value,
    output logic                          o_done,
    output logic [psbd_pkg::DiamBits-1:0] o_root
);

    localparam int BitCntW = $clog2(psbd_pkg::DiamBits + 1);

    logic [psbd_pkg::DiamBits:0]   r_res, n_res;
    logic [BitCntW-1:0]            r_bit, n_bit;
    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [psbd_pkg::DiamBits:0]   w_try;
    logic [2*psbd_pkg::DiamBits+1:0] w_sq;
    logic [psbd_pkg::SqBits-1:0]   r_val;

    // Try setting the current bit and keep it when the square still fits.
    always_comb begin
        w_try  = r_res | ((psbd_pkg::DiamBits+1)'(1) << r_bit);
        w_sq   = (2*psbd_pkg::DiamBits+2)'(w_try) * (2*psbd_pkg::DiamBits+2)'(w_try);
        n_res  = r_res;
        n_bit  = r_bit;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_res  = '0;
            n_bit  = BitCntW'(psbd_pkg::DiamBits);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sq <= (2*psbd_pkg::DiamBits+2)'(r_val)) begin
                n_res = w_try;
            end
            if (r_bit == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_bit = r_bit - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_res <= n_res;
        r_bit <= n_bit;
        if (i_start) begin
            r_val <= i_value;
        end
    end

    // Saturate to the all-ones diameter.
    assign o_done = r_done;
    assign o_root = r_res[psbd_pkg::DiamBits] ? '1 : r_res[psbd_pkg::DiamBits-1:0];

endmodule

// ===== rtl/point_set_bounds_and_diameter_top.sv =====
// Sequence: vertex beats are stored in the load state; after the last beat come a setup
// state, per unordered pair the read-i, read-j, DX, DY, DZ and SUM states, then the root
// and the result state. Pairs share the single squaring unit and the single vertex RAM
// read port; a new set is taken only in the load state, and input waits on a held result.
// Reset: synchronous active-low i_rst_n clears the sequencer and set state;
// the vertex RAM is not cleared, as only entries written in the current set are read.
module point_set_bounds_and_diameter_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,   // vertex_x, vertex_y, vertex_z
    input  logic         s_axis_tlast,   // last_vertex
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [183:0] m_axis_tdata    // min_x..z, max_x..z, diameter, vertex_count, overflowed
);

    localparam int CB = psbd_pkg::CoordBits;
    localparam int AB = psbd_pkg::AddrBits;
    localparam int NB = psbd_pkg::CountBits;

    psbd_pkg::t_state r_state, n_state;

    logic [NB-1:0] r_count;
    logic          r_ovf;
    logic [AB-1:0] r_i, r_j;
    logic [psbd_pkg::SqBits-1:0] r_best;
    logic signed [CB-1:0] r_lo [3];
    logic signed [CB-1:0] r_hi [3];
    logic signed [CB-1:0] r_pi [3];
    logic signed [CB-1:0] r_pj [3];
    logic          r_phase;     // 0: reading vertex i, 1: reading vertex j
    logic [183:0]  r_out;
    logic          r_ovalid;

    logic                  w_acc;
    logic                  w_store;
    logic [AB-1:0]         w_raddr;
    logic [psbd_pkg::VecBits-1:0] w_rdata;
    logic signed [CB-1:0]  w_p [3];
    psbd_pkg::t_sq_ctl     w_sq_ctl;
    logic                  w_sq_en;
    logic signed [CB-1:0]  w_a, w_b;
    logic [psbd_pkg::SqBits-1:0] w_sum;
    logic [psbd_pkg::SqBits-1:0] w_sat;
    logic                  w_sqrt_start;
    logic                  w_sqrt_done;
    logic [psbd_pkg::DiamBits-1:0] w_root;

    assign w_p[0] = s_axis_tdata[CB-1:0];
    assign w_p[1] = s_axis_tdata[2*CB-1:CB];
    assign w_p[2] = s_axis_tdata[3*CB-1:2*CB];

    assign s_axis_tready = (r_state == psbd_pkg::ST_LOAD) && !r_ovalid;
    assign w_acc   = s_axis_tvalid && s_axis_tready;
    assign w_store = w_acc && (r_count < NB'(psbd_pkg::MaxVertices));

    // Vertex store.
    psbd_ram #(.Width(psbd_pkg::VecBits), .Depth(psbd_pkg::MaxVertices)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_count[AB-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_raddr = r_phase ? r_j : r_i;

    // Shared squaring unit. Vertex j lands on the read port during the X step,
    // so that step takes it straight from the RAM.
    always_comb begin
        w_sq_ctl.start = (r_state == psbd_pkg::ST_DX);
        w_sq_ctl.axis  = (r_state == psbd_pkg::ST_DX) ? 2'd0 :
                         (r_state == psbd_pkg::ST_DY) ? 2'd1 : 2'd2;
        w_sq_en = (r_state == psbd_pkg::ST_DX) || (r_state == psbd_pkg::ST_DY) ||
                  (r_state == psbd_pkg::ST_DZ);
        unique case (w_sq_ctl.axis)
            2'd0:    begin w_a = r_pi[0]; w_b = w_rdata[CB-1:0]; end
            2'd1:    begin w_a = r_pi[1]; w_b = r_pj[1]; end
            default: begin w_a = r_pi[2]; w_b = r_pj[2]; end
        endcase
    end

    psbd_sq_unit u_sq (
        .i_clk (i_clk),
        .i_ctl (w_sq_ctl),
        .i_en  (w_sq_en),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_sum (w_sum)
    );

    // Saturate at 2^50; an axis difference above 2^25 already exceeds it.
    assign w_sat = (w_sum > (psbd_pkg::SqBits'(1) << (2*psbd_pkg::DiamBits))) ?
                   (psbd_pkg::SqBits'(1) << (2*psbd_pkg::DiamBits)) : w_sum;

    assign w_sqrt_start = (r_state == psbd_pkg::ST_SQRT) && !r_phase;

    psbd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_value (r_best),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psbd_pkg::ST_LOAD: if (w_acc && s_axis_tlast) n_state = psbd_pkg::ST_RD;
            psbd_pkg::ST_RD: begin
                if (r_count < NB'(2)) n_state = psbd_pkg::ST_SQRT;
                else                  n_state = psbd_pkg::ST_WAIT;
            end
            psbd_pkg::ST_WAIT: n_state = r_phase ? psbd_pkg::ST_DX : psbd_pkg::ST_WAIT;
            psbd_pkg::ST_DX:   n_state = psbd_pkg::ST_DY;
            psbd_pkg::ST_DY:   n_state = psbd_pkg::ST_DZ;
            psbd_pkg::ST_DZ:   n_state = psbd_pkg::ST_SUM;
            psbd_pkg::ST_SUM: begin
                if ({1'b0, r_i} + NB'(2) >= r_count && {1'b0, r_j} + NB'(1) >= r_count)
                    n_state = psbd_pkg::ST_SQRT;
                else
                    n_state = psbd_pkg::ST_WAIT;
            end
            psbd_pkg::ST_SQRT: if (w_sqrt_done) n_state = psbd_pkg::ST_OUT;
            psbd_pkg::ST_OUT:  n_state = psbd_pkg::ST_LOAD;
            default:           n_state = psbd_pkg::ST_LOAD;
        endcase
    end

    // Datapath and set state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= psbd_pkg::ST_LOAD;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_best   <= '0;
            r_phase  <= 1'b0;
            r_ovalid <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                psbd_pkg::ST_LOAD: begin
                    if (w_store) begin
                        for (int k = 0; k < 3; k++) begin
                            if (r_count == '0 || w_p[k] < r_lo[k]) r_lo[k] <= w_p[k];
                            if (r_count == '0 || w_p[k] > r_hi[k]) r_hi[k] <= w_p[k];
                        end
                        r_count <= r_count + 1'b1;
                    end else if (w_acc) begin
                        r_ovf <= 1'b1;
                    end
                    r_i     <= '0;
                    r_j     <= AB'(1);
                    r_phase <= 1'b0;
                end
                psbd_pkg::ST_RD: r_phase <= 1'b0;
                psbd_pkg::ST_WAIT: begin
                    // Vertex i read is issued in phase 0, j in phase 1.
                    if (!r_phase) begin
                        r_phase <= 1'b1;
                    end else begin
                        r_phase <= 1'b0;
                    end
                end
                psbd_pkg::ST_SUM: begin
                    if (w_sat > r_best) r_best <= w_sat;
                    if ({1'b0, r_j} + NB'(1) >= r_count) begin
                        r_i <= r_i + 1'b1;
                        r_j <= r_i + AB'(2);
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                    r_phase <= 1'b0;
                end
                psbd_pkg::ST_SQRT: r_phase <= 1'b1;
                psbd_pkg::ST_OUT: begin
                    r_ovalid <= 1'b1;
                    r_count  <= '0;
                    r_ovf    <= 1'b0;
                    r_best   <= '0;
                    r_phase  <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Capture the vertex pair as the registered reads return.
    always_ff @(posedge i_clk) begin
        if (r_state == psbd_pkg::ST_WAIT && r_phase) begin
            for (int k = 0; k < 3; k++) r_pi[k] <= w_rdata[k*CB +: CB];
        end
        if (r_state == psbd_pkg::ST_DX) begin
            for (int k = 0; k < 3; k++) r_pj[k] <= w_rdata[k*CB +: CB];
        end
    end

    // Result beat register.
    always_ff @(posedge i_clk) begin
        if (r_state == psbd_pkg::ST_OUT) begin
            r_out <= {1'b0, r_ovf, r_count, w_root,
                      r_hi[2], r_hi[1], r_hi[0], r_lo[2], r_lo[1], r_lo[0]};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

`ifndef NO_ASSERTIONS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NB'(psbd_pkg::MaxVertices))
        else $error("vertex count beyond capacity");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != psbd_pkg::ST_LOAD) |-> !s_axis_tready)
        else $error("input ready while walking pairs");
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == psbd_pkg::ST_OUT)
        else $error("result raised outside output step");
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psbd_pkg::ST_DX) |-> (r_j > r_i))
        else $error("pair walk out of order");
`endif

endmodule
